// ===== rtl/core/assert_macros.svh =====
// Assertion shorthands shared by the core RTL.
// All of them sample on clk_i and are disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rfc_pkg.sv =====
`timescale 1ns / 1ps

package rfc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int STACK_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int FILL_W      = $clog2(STACK_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [SAMPLE_BITS-1:0] range_t;
  typedef logic        [FILL_W-1:0]      fill_t;
  typedef logic        [ADDR_W-1:0]      addr_t;

  typedef enum logic [1:0] {
    KIND_FULL = 2'd0,
    KIND_HALF = 2'd1,
    KIND_OVFL = 2'd2
  } kind_e;

  // Up to two stack pushes requested by one input word
  typedef struct packed {
    logic    push_a;
    sample_t val_a;
    logic    push_b;
    sample_t val_b;
    logic    eor;
  } job_t;

  // One counted range
  typedef struct packed {
    kind_e   kind;
    range_t  cyc_range;
    sample_t start_v;
    sample_t end_v;
  } rec_t;

  // |a - b| without overflow
  function automatic range_t span(sample_t a, sample_t b);
    logic signed [SAMPLE_BITS:0] diff;
    diff = (SAMPLE_BITS + 1)'(a) - (SAMPLE_BITS + 1)'(b);
    if (diff < 0) begin
      diff = -diff;
    end
    return diff[SAMPLE_BITS-1:0];
  endfunction

endpackage

// ===== rtl/core/rfc_if.sv =====
`timescale 1ns / 1ps

// Sample stream
interface rfc_in_if;
  logic             valid;
  logic             ready;
  rfc_pkg::sample_t sample;
  logic             end_of_record;

  modport source (output valid, sample, end_of_record, input ready);
  modport sink   (input valid, sample, end_of_record, output ready);
endinterface

// Counted-range stream
interface rfc_out_if;
  logic             valid;
  logic             ready;
  logic [1:0]       record_kind;
  rfc_pkg::range_t  cycle_range;
  rfc_pkg::sample_t start_value;
  rfc_pkg::sample_t end_value;
  logic             last_of_run;

  modport source (output valid, record_kind, cycle_range, start_value, end_value,
                  last_of_run, input ready);
  modport sink   (input valid, record_kind, cycle_range, start_value, end_value,
                  last_of_run, output ready);
endinterface

// ===== rtl/core/rfc_ram.sv =====
`timescale 1ns / 1ps

module rfc_ram #(
  parameter int Width = 16,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rfc_detect.sv =====
`timescale 1ns / 1ps

module rfc_detect (
  input  logic          clk_i,
  input  logic          rst_ni,
  rfc_in_if.sink        in_i,
  input  logic          idle_i,
  output logic          job_vld_o,
  output rfc_pkg::job_t job_o
);

  localparam int W = rfc_pkg::SAMPLE_BITS;

  rfc_pkg::sample_t prev_q, prev_d;
  rfc_pkg::sample_t sbp_q, sbp_d;
  logic [1:0]       seen_q, seen_d;
  logic             accept;
  logic signed [W:0] slope_in, slope_out;
  logic             rev;

  assign in_i.ready = idle_i;
  assign accept     = in_i.valid & idle_i;
  assign job_vld_o  = accept;

  // slope reversal at the previous sample
  always_comb begin
    slope_in  = (W + 1)'(prev_q) - (W + 1)'(sbp_q);
    slope_out = (W + 1)'(in_i.sample) - (W + 1)'(prev_q);
    rev = ((slope_in > 0) && (slope_out <= 0)) || ((slope_in < 0) && (slope_out >= 0));
  end

  // pushes for this word: first sample, reversal, last sample
  always_comb begin
    job_o.eor    = in_i.end_of_record;
    job_o.val_b  = in_i.sample;
    job_o.push_b = in_i.end_of_record;
    if (seen_q == 2'd0) begin
      job_o.push_a = 1'b1;
      job_o.val_a  = in_i.sample;
    end else begin
      job_o.push_a = seen_q[1] & rev;
      job_o.val_a  = prev_q;
    end
  end

  // history update; end of record clears it
  always_comb begin
    prev_d = prev_q;
    sbp_d  = sbp_q;
    seen_d = seen_q;
    if (accept) begin
      if (in_i.end_of_record) begin
        prev_d = '0;
        sbp_d  = '0;
        seen_d = '0;
      end else begin
        prev_d = in_i.sample;
        sbp_d  = prev_q;
        seen_d = seen_q[1] ? seen_q : seen_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      sbp_q  <= '0;
      seen_q <= '0;
    end else begin
      prev_q <= prev_d;
      sbp_q  <= sbp_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ===== rtl/core/rfc_out.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rfc_out (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rec_vld_i,
  input  rfc_pkg::rec_t rec_i,
  input  logic          close_i,
  output logic          ok_o,
  rfc_out_if.source     out_o
);

  rfc_pkg::rec_t pend_q, pend_d;
  logic          pend_vld_q, pend_vld_d;
  rfc_pkg::rec_t out_q, out_d;
  logic          out_vld_q, out_vld_d;
  logic          last_q, last_d;
  logic          move;

  // one record is held back until we know whether another follows
  assign ok_o = !(pend_vld_q && out_vld_q && !out_o.ready);
  assign move = ok_o && pend_vld_q && (rec_vld_i || close_i);

  always_comb begin
    out_d      = out_q;
    last_d     = last_q;
    out_vld_d  = out_vld_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    if (move) begin
      out_d     = pend_q;
      last_d    = close_i;
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (ok_o && rec_vld_i) begin
      pend_d     = rec_i;
      pend_vld_d = 1'b1;
    end else if (ok_o && close_i) begin
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    last_q <= last_d;
    pend_q <= pend_d;
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.record_kind = out_q.kind;
  assign out_o.cycle_range = out_q.cyc_range;
  assign out_o.start_value = out_q.start_v;
  assign out_o.end_value   = out_q.end_v;
  assign out_o.last_of_run = last_q;

  `ASSERT_IMPL(rec_close_excl, rec_vld_i, !close_i, "record and close in one cycle")
  `ASSERT_NEXT(close_drains, close_i && ok_o, !pend_vld_q, "held record kept after close")
  `ASSERT_NEXT(rec_taken, rec_vld_i && ok_o, pend_vld_q, "granted record not held")

endmodule

// ===== rtl/core/rfc_ctrl.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module rfc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_vld_i,
  input  rfc_pkg::job_t job_i,
  output logic          idle_o,
  output logic          rec_vld_o,
  output rfc_pkg::rec_t rec_o,
  output logic          close_o,
  input  logic          ok_i
);

  localparam int FW = rfc_pkg::FILL_W;
  localparam int AW = rfc_pkg::ADDR_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PUSH  = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_REF1  = 4'd3;
  localparam logic [3:0] S_REF2  = 4'd4;
  localparam logic [3:0] S_REF3  = 4'd5;
  localparam logic [3:0] S_FLRD  = 4'd6;
  localparam logic [3:0] S_FLUSE = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  localparam rfc_pkg::fill_t F2        = FW'(2);
  localparam rfc_pkg::fill_t F3        = FW'(3);
  localparam rfc_pkg::fill_t FILL_FULL = FW'(rfc_pkg::STACK_DEPTH);

  logic [3:0]       state_q, state_d;
  rfc_pkg::fill_t   fill_q, fill_d;
  rfc_pkg::fill_t   idx_q, idx_d;
  // top three stack entries: c0 newest; memory holds everything below them
  rfc_pkg::sample_t c0_q, c0_d, c1_q, c1_d, c2_q, c2_d;
  rfc_pkg::sample_t pa_q, pa_d, pb_q, pb_d, fprev_q, fprev_d;
  logic             pa_vld_q, pa_vld_d, pb_vld_q, pb_vld_d, eor_q, eor_d;

  logic             we, re;
  rfc_pkg::addr_t   waddr, raddr;
  logic [rfc_pkg::SAMPLE_BITS-1:0] rdata;
  rfc_pkg::sample_t ram_v, cur_v, cache_v, fl_v;
  rfc_pkg::range_t  x_rng, y_rng;
  rfc_pkg::fill_t   fill_m2, fill_m3, kidx;
  logic [FW:0]      idx_p3;
  logic             rule, from_ram, fl_emit;
  logic [3:0]       after_st;

  rfc_ram #(
    .Width (rfc_pkg::SAMPLE_BITS),
    .Depth (rfc_pkg::STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (c2_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // datapath helpers
  always_comb begin
    ram_v    = rfc_pkg::sample_t'(rdata);
    cur_v    = pa_vld_q ? pa_q : pb_q;
    x_rng    = rfc_pkg::span(c0_q, c1_q);
    y_rng    = rfc_pkg::span(c1_q, c2_q);
    rule     = (fill_q >= F3) && (x_rng >= y_rng) && (y_rng != '0);
    fill_m2  = fill_q - F2;
    fill_m3  = fill_q - F3;
    idx_p3   = {1'b0, idx_q} + (FW + 1)'(3);
    from_ram = idx_p3 < {1'b0, fill_q};
    kidx     = fill_q - idx_q - FW'(1);
    case (kidx[1:0])
      2'd0:    cache_v = c0_q;
      2'd1:    cache_v = c1_q;
      default: cache_v = c2_q;
    endcase
    fl_v     = from_ram ? ram_v : cache_v;
    fl_emit  = (idx_q != '0) && (fl_v != fprev_q);
    if (pa_vld_q || pb_vld_q) begin
      after_st = S_PUSH;
    end else if (eor_q) begin
      after_st = S_FLRD;
    end else begin
      after_st = S_FIN;
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    idx_d     = idx_q;
    c0_d      = c0_q;
    c1_d      = c1_q;
    c2_d      = c2_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    pa_vld_d  = pa_vld_q;
    pb_vld_d  = pb_vld_q;
    eor_d     = eor_q;
    fprev_d   = fprev_q;
    we        = 1'b0;
    waddr     = fill_m3[AW-1:0];
    re        = 1'b0;
    raddr     = '0;
    rec_vld_o = 1'b0;
    rec_o     = '{kind: rfc_pkg::KIND_HALF, cyc_range: y_rng, start_v: c2_q, end_v: c1_q};
    close_o   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (job_vld_i) begin
          pa_vld_d = job_i.push_a;
          pa_d     = job_i.val_a;
          pb_vld_d = job_i.push_b;
          pb_d     = job_i.val_b;
          eor_d    = job_i.eor;
          idx_d    = '0;
          if (job_i.push_a || job_i.push_b) begin
            state_d = S_PUSH;
          end else if (job_i.eor) begin
            state_d = S_FLRD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_PUSH: begin
        if (fill_q == FILL_FULL) begin
          // stack full: drop the point and warn
          rec_vld_o = 1'b1;
          rec_o     = '{kind: rfc_pkg::KIND_OVFL, cyc_range: '0, start_v: cur_v, end_v: '0};
        end
        if (fill_q != FILL_FULL || ok_i) begin
          if (fill_q != FILL_FULL) begin
            we     = fill_q >= F3;
            c2_d   = c1_q;
            c1_d   = c0_q;
            c0_d   = cur_v;
            fill_d = fill_q + FW'(1);
          end
          if (pa_vld_q) begin
            pa_vld_d = 1'b0;
          end else begin
            pb_vld_d = 1'b0;
          end
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rule) begin
          rec_vld_o = 1'b1;
          rec_o.kind = (fill_q == F3) ? rfc_pkg::KIND_HALF : rfc_pkg::KIND_FULL;
          if (ok_i) begin
            if (fill_q == F3) begin
              // start point dropped; remaining two stay cached
              fill_d = F2;
            end else begin
              fill_d  = fill_m2;
              state_d = S_REF1;
            end
          end
        end else begin
          state_d = after_st;
        end
      end
      S_REF1: begin
        re      = 1'b1;
        raddr   = fill_m2[AW-1:0];
        state_d = S_REF2;
      end
      S_REF2: begin
        c1_d = ram_v;
        if (fill_q >= F3) begin
          re      = 1'b1;
          raddr   = fill_m3[AW-1:0];
          state_d = S_REF3;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_REF3: begin
        c2_d    = ram_v;
        state_d = S_CHECK;
      end
      S_FLRD: begin
        if (idx_q == fill_q) begin
          state_d = S_FIN;
        end else begin
          re      = from_ram;
          raddr   = idx_q[AW-1:0];
          state_d = S_FLUSE;
        end
      end
      S_FLUSE: begin
        rec_vld_o = fl_emit;
        rec_o     = '{kind: rfc_pkg::KIND_HALF, cyc_range: rfc_pkg::span(fprev_q, fl_v),
                      start_v: fprev_q, end_v: fl_v};
        if (!fl_emit || ok_i) begin
          fprev_d = fl_v;
          idx_d   = idx_q + FW'(1);
          state_d = S_FLRD;
        end
      end
      S_FIN: begin
        close_o = 1'b1;
        if (ok_i) begin
          if (eor_q) begin
            fill_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      fill_q   <= '0;
      pa_vld_q <= 1'b0;
      pb_vld_q <= 1'b0;
      eor_q    <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      pa_vld_q <= pa_vld_d;
      pb_vld_q <= pb_vld_d;
      eor_q    <= eor_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c0_q    <= c0_d;
    c1_q    <= c1_d;
    c2_q    <= c2_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    fprev_q <= fprev_d;
  end

  assign idle_o = (state_q == S_IDLE);

  `ASSERT_ALWAYS(fill_bound, fill_q <= FILL_FULL, "stack fill beyond depth")
  `ASSERT_IMPL(no_rw_clash, we && re, waddr != raddr, "read and write of one entry")
  `ASSERT_IMPL(job_when_idle, job_vld_i, state_q == S_IDLE, "word taken while busy")

endmodule

// ===== rtl/core/rainflow_cycle_counter.sv =====
// Channel  Dir  Fields                                              Accept
// in_i     in   sample, end_of_record                               valid & ready
// out_o    out  record_kind, cycle_range, start_value, end_value,   valid & ready
//               last_of_run
//
// A full cycle reloads the cached top entries through the stack memory's
// single read port, and end of record reads back every stack entry.
// Reset clears fill and history; the stack memory is not cleared. A
// stalled output holds one record and one more is kept back, after which
// the sequencer waits.
`timescale 1ns / 1ps

module rainflow_cycle_counter (
  input  logic      clk_i,
  input  logic      rst_ni,
  rfc_in_if.sink    in_i,
  rfc_out_if.source out_o
);

  logic          idle;
  logic          job_vld;
  rfc_pkg::job_t job;
  logic          rec_vld;
  rfc_pkg::rec_t rec;
  logic          close;
  logic          ok;

  rfc_detect u_detect (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .idle_i    (idle),
    .job_vld_o (job_vld),
    .job_o     (job)
  );

  rfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_vld_i (job_vld),
    .job_i     (job),
    .idle_o    (idle),
    .rec_vld_o (rec_vld),
    .rec_o     (rec),
    .close_o   (close),
    .ok_i      (ok)
  );

  rfc_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rec_vld_i (rec_vld),
    .rec_i     (rec),
    .close_i   (close),
    .ok_o      (ok),
    .out_o     (out_o)
  );

endmodule

// ===== verif/tb_rainflow_cycle_counter.sv =====
`timescale 1ns / 1ps

module tb_rainflow_cycle_counter;
  import rfc_pkg::*;

  localparam int CLK_HALF    = 5;
  localparam int RST_CYCLES  = 10;
  localparam int ITEMS       = 460;
  localparam int MAX_PER_WORD = 64;
  localparam int TAIL_CYCLES = 200;
  localparam int QUIET_LIMIT = 4000;
  localparam int SMP_MAX     = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int SMP_MIN     = -(2 ** (SAMPLE_BITS - 1));
  localparam int N_DIR       = 24;

  // One counted range as it should leave the block
  typedef struct packed {
    kind_e   kind;
    range_t  rng;
    sample_t v_old;
    sample_t v_new;
    logic    last;
  } cycle_rec_t;

  // Directed row; fixed_cnt < 0 means the predictor supplies the results
  typedef struct {
    sample_t smp;
    logic    eor;
    int      fixed_cnt;
    kind_e   kind;
    range_t  rng;
    sample_t v_old;
    sample_t v_new;
  } dir_row_t;

  typedef enum int {SHAPE_SWING, SHAPE_CONVERGE, SHAPE_DIVERGE, SHAPE_NOISE} shape_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  rfc_in_if  smp_if ();
  rfc_out_if cyc_if ();

  rainflow_cycle_counter uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .out_o  (cyc_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Predictor state: sample history and the stack of turning points
  sample_t hist1, hist2;
  int      hist_cnt;
  sample_t turn_pts [STACK_DEPTH];
  int      turn_cnt;
  cycle_rec_t step_recs [$];
  cycle_rec_t pending_ranges [$];

  int words_sent, records_sent, ranges_seen, mismatches;
  int n_full, n_half, n_ovfl;
  int quiet_cycles = 0;
  int tx_idle_pct, rx_stall_pct;

  dir_row_t dir_tbl [N_DIR] = '{
    // single-sample record: nothing counted
    '{0,      1'b1, 0,  KIND_HALF, 0,     0,      0},
    // full-scale swing, one half cycle at end of record
    '{-32768, 1'b0, 0,  KIND_HALF, 0,     0,      0},
    '{32767,  1'b1, 1,  KIND_HALF, 65535, -32768, 32767},
    '{32767,  1'b1, 0,  KIND_HALF, 0,     0,      0},
    '{-32768, 1'b1, 0,  KIND_HALF, 0,     0,      0},
    // flat two-sample record: zero residual range is skipped
    '{3,      1'b0, 0,  KIND_HALF, 0,     0,      0},
    '{3,      1'b1, 0,  KIND_HALF, 0,     0,      0},
    // nested ranges: full cycles then residual halves
    '{0,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{10,     1'b0, -1, KIND_HALF, 0,     0,      0},
    '{2,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{8,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{4,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{20,     1'b0, -1, KIND_HALF, 0,     0,      0},
    '{-5,     1'b1, -1, KIND_HALF, 0,     0,      0},
    // plateau at the top, last point equals last reversal
    '{1,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{9,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{9,      1'b1, -1, KIND_HALF, 0,     0,      0},
    // range containing the start point becomes a half cycle
    '{0,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{10,     1'b0, -1, KIND_HALF, 0,     0,      0},
    '{-20,    1'b1, -1, KIND_HALF, 0,     0,      0},
    // flat runs on both sides of a fall
    '{5,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{5,      1'b0, -1, KIND_HALF, 0,     0,      0},
    '{-7,     1'b0, -1, KIND_HALF, 0,     0,      0},
    '{-7,     1'b1, -1, KIND_HALF, 0,     0,      0}
  };

  function automatic range_t abs_gap(sample_t a, sample_t b);
    int d;
    d = int'(a) - int'(b);
    return range_t'((d < 0) ? -d : d);
  endfunction

  function automatic sample_t clip(int x);
    if (x > SMP_MAX) begin
      return sample_t'(SMP_MAX);
    end
    if (x < SMP_MIN) begin
      return sample_t'(SMP_MIN);
    end
    return sample_t'(x);
  endfunction

  function automatic void clear_counter_state();
    hist1    = '0;
    hist2    = '0;
    hist_cnt = 0;
    turn_cnt = 0;
  endfunction

  function automatic void add_rec(kind_e kind, range_t rng, sample_t a, sample_t b);
    cycle_rec_t r;
    if (step_recs.size() < MAX_PER_WORD) begin
      r.kind  = kind;
      r.rng   = rng;
      r.v_old = a;
      r.v_new = b;
      r.last  = 1'b0;
      step_recs.insert(step_recs.size(), r);
    end
  endfunction

  // Push a turning point and resolve ranges until no rule applies
  function automatic void push_turn(sample_t v);
    int     f;
    range_t x, y;
    bit     done;
    if (turn_cnt >= STACK_DEPTH) begin
      add_rec(KIND_OVFL, '0, v, '0);
      return;
    end
    turn_pts[turn_cnt] = v;
    turn_cnt++;
    done = 1'b0;
    while (!done && turn_cnt >= 3) begin
      f = turn_cnt;
      x = abs_gap(turn_pts[f-1], turn_pts[f-2]);
      y = abs_gap(turn_pts[f-2], turn_pts[f-3]);
      if (x < y || y == 0) begin
        done = 1'b1;
      end else if (f == 3) begin
        // range holds the start point: half cycle, oldest point leaves
        add_rec(KIND_HALF, y, turn_pts[0], turn_pts[1]);
        turn_pts[0] = turn_pts[1];
        turn_pts[1] = turn_pts[2];
        turn_cnt    = 2;
      end else begin
        add_rec(KIND_FULL, y, turn_pts[f-3], turn_pts[f-2]);
        turn_pts[f-3] = turn_pts[f-1];
        turn_cnt      = f - 2;
      end
    end
  endfunction

  // Expected ranges for one accepted sample word, left in step_recs
  function automatic void count_sample(sample_t s, logic eor);
    int         d1, d2;
    range_t     r;
    step_recs.delete();
    if (hist_cnt == 0) begin
      push_turn(s);
      if (eor) begin
        push_turn(s);
      end
    end else begin
      if (hist_cnt >= 2) begin
        d1 = int'(hist1) - int'(hist2);
        d2 = int'(s) - int'(hist1);
        if ((d1 > 0 && d2 <= 0) || (d1 < 0 && d2 >= 0)) begin
          push_turn(hist1);
        end
      end
      if (eor) begin
        push_turn(s);
      end
    end
    hist2 = hist1;
    hist1 = s;
    if (hist_cnt < 2) begin
      hist_cnt++;
    end
    // end of record: flush residual nonzero pairs as halves, then clear
    if (eor) begin
      for (int i = 0; i + 1 < turn_cnt; i++) begin
        r = abs_gap(turn_pts[i], turn_pts[i+1]);
        if (r != 0) begin
          add_rec(KIND_HALF, r, turn_pts[i], turn_pts[i+1]);
        end
      end
      clear_counter_state();
    end
    if (step_recs.size() > 0) begin
      step_recs[step_recs.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("[%0t] mismatch, %0s: got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Offer one word, idling at random first; returns at the accepting edge
  task automatic put_sample(input sample_t s, input logic eor);
    while ($urandom_range(99) < tx_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    smp_if.valid         <= 1'b1;
    smp_if.sample        <= s;
    smp_if.end_of_record <= eor;
    @(posedge clk_i);
    while (!smp_if.ready) begin
      @(posedge clk_i);
    end
    words_sent++;
    if (eor) begin
      records_sent++;
    end
  endtask

  task automatic feed_sample(input sample_t s, input logic eor);
    put_sample(s, eor);
    count_sample(s, eor);
    foreach (step_recs[i]) begin
      pending_ranges.insert(pending_ranges.size(), step_recs[i]);
    end
  endtask

  // Stop sending until every expected range has come out
  task automatic drain_pending();
    smp_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_ranges.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // One record of the given shape, end of record on its last sample
  task automatic send_record(input shape_e shape);
    int      len, mid, amp;
    sample_t v, prev_v;
    case (shape)
      SHAPE_SWING:    len = $urandom_range(16, 2);
      SHAPE_CONVERGE: len = $urandom_range(44, 36);
      SHAPE_DIVERGE:  len = $urandom_range(20, 6);
      default:        len = $urandom_range(12, 1);
    endcase
    mid    = (shape == SHAPE_CONVERGE) ? 0 : int'($urandom_range(40000)) - 20000;
    amp    = (shape == SHAPE_CONVERGE) ? 32000 : 100;
    prev_v = '0;
    for (int k = 0; k < len; k++) begin
      case (shape)
        SHAPE_SWING: begin
          if (k > 0 && $urandom_range(5) == 0) begin
            v = prev_v;
          end else if ($urandom_range(9) == 0) begin
            v = ($urandom_range(1) == 1) ? sample_t'(SMP_MAX) : sample_t'(SMP_MIN);
          end else begin
            amp = int'($urandom_range(12000));
            v   = clip(mid + ((k % 2 == 1) ? amp : -amp));
          end
        end
        SHAPE_CONVERGE: begin
          // shrinking swings never resolve, so the stack fills up
          amp = amp - int'($urandom_range(700, 1));
          v   = clip((k % 2 == 1) ? amp : -amp);
        end
        SHAPE_DIVERGE: begin
          amp = amp + int'($urandom_range(1500, 50));
          v   = clip(mid + ((k % 2 == 1) ? amp : -amp));
        end
        default: begin
          v = sample_t'($urandom);
        end
      endcase
      feed_sample(v, k == len - 1);
      prev_v = v;
    end
  endtask

  // Receiver: random stalls
  always @(posedge clk_i) begin
    cyc_if.ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Range checker and handshake activity counter
  always @(posedge clk_i) begin : chk
    cycle_rec_t want;
    if ((smp_if.valid && smp_if.ready) || (cyc_if.valid && cyc_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (rst_ni && cyc_if.valid && cyc_if.ready) begin
      ranges_seen++;
      if (pending_ranges.size() == 0) begin
        flag_mismatch("word with nothing pending, kind", 32'(cyc_if.record_kind), '0);
      end else begin
        want = pending_ranges.pop_front();
        case (want.kind)
          KIND_FULL: n_full++;
          KIND_HALF: n_half++;
          default:   n_ovfl++;
        endcase
        if (cyc_if.record_kind !== want.kind) begin
          flag_mismatch("record_kind", 32'(cyc_if.record_kind), 32'(want.kind));
        end
        if (cyc_if.cycle_range !== want.rng) begin
          flag_mismatch("cycle_range", 32'(cyc_if.cycle_range), 32'(want.rng));
        end
        if (cyc_if.start_value !== want.v_old) begin
          flag_mismatch("start_value", 32'(cyc_if.start_value), 32'(want.v_old));
        end
        if (cyc_if.end_value !== want.v_new) begin
          flag_mismatch("end_value", 32'(cyc_if.end_value), 32'(want.v_new));
        end
        if (cyc_if.last_of_run !== want.last) begin
          flag_mismatch("last_of_run", 32'(cyc_if.last_of_run), 32'(want.last));
        end
      end
    end
  end

  // Watchdog on handshake activity
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk_i);
    end
    $display("watchdog: no word moved for %0d cycles, %0d ranges outstanding",
             QUIET_LIMIT, pending_ranges.size());
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus
  initial begin : stim
    int         pick;
    shape_e     shp;
    cycle_rec_t fixed;
    words_sent   = 0;
    records_sent = 0;
    ranges_seen  = 0;
    mismatches   = 0;
    n_full       = 0;
    n_half       = 0;
    n_ovfl       = 0;
    tx_idle_pct  = 20;
    rx_stall_pct = 70;
    clear_counter_state();
    rst_ni               <= 1'b0;
    smp_if.valid         <= 1'b0;
    smp_if.sample        <= '0;
    smp_if.end_of_record <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct  = (phase == 0) ? 20 : (phase == 1) ? 70 : 0;
      rx_stall_pct = (phase == 0) ? 70 : (phase == 1) ? 20 : 0;
      if (phase == 0) begin
        foreach (dir_tbl[i]) begin
          put_sample(dir_tbl[i].smp, dir_tbl[i].eor);
          count_sample(dir_tbl[i].smp, dir_tbl[i].eor);
          if (dir_tbl[i].fixed_cnt < 0) begin
            foreach (step_recs[j]) begin
              pending_ranges.insert(pending_ranges.size(), step_recs[j]);
            end
          end else if (dir_tbl[i].fixed_cnt == 1) begin
            fixed.kind  = dir_tbl[i].kind;
            fixed.rng   = dir_tbl[i].rng;
            fixed.v_old = dir_tbl[i].v_old;
            fixed.v_new = dir_tbl[i].v_new;
            fixed.last  = 1'b1;
            pending_ranges.insert(pending_ranges.size(), fixed);
          end
        end
        // stack full: overflow warnings, then a long residual flush
        send_record(SHAPE_CONVERGE);
      end else begin
        drain_pending();
      end
      while (words_sent < (phase + 1) * ITEMS / 3) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          shp = SHAPE_SWING;
        end else if (pick < 68) begin
          shp = SHAPE_CONVERGE;
        end else if (pick < 82) begin
          shp = SHAPE_DIVERGE;
        end else begin
          shp = SHAPE_NOISE;
        end
        send_record(shp);
      end
    end

    drain_pending();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_ranges.size() != 0) begin
      flag_mismatch("ranges never produced", pending_ranges.size(), '0);
    end
    $display("%0d samples in %0d records under three idle/stall mixes", words_sent,
             records_sent);
    $display("%0d ranges checked: %0d full, %0d half, %0d stack-full warnings",
             ranges_seen, n_full, n_half, n_ovfl);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
